>>> src/srre_pkg.sv
`timescale 1ns / 1ps

package srre_pkg;

   // Fixed field widths of the channels.
   localparam int MaskWidth  = 64;
   localparam int IdWidth    = 6;
   localparam int PosWidth   = 16;
   localparam int CountWidth = 7;

   // Defaults for the top-level parameters.
   localparam int DefaultMaxSubmeshes = 64;
   localparam int DefaultMaxItems     = 65536;

   // Register file layout.
   localparam int CsrAddrWidth = 3;
   localparam int CsrDataWidth = 32;
   localparam logic [CsrAddrWidth-1:0] RegNumSubmeshes = 3'd0;
   localparam logic [CountWidth-1:0] NumSubmeshesReset = 7'd64;

   // One finished range waiting in the cell chain.
   typedef struct packed {
      logic                valid;
      logic [IdWidth-1:0]  id;
      logic [PosWidth-1:0] start;
      logic [PosWidth-1:0] stop;
   } rec_type;

   // Controls broadcast to every cell.
   typedef struct packed {
      logic                load;
      logic                last;
      logic                shift;
      logic [PosWidth-1:0] pos;
   } ctl_type;

endpackage

>>> src/srre_cell.sv
`timescale 1ns / 1ps

module srre_cell #(
   parameter int CELL_ID = 0
) (
   input  logic             clock,
   input  logic             reset,
   input  srre_pkg::ctl_type ctl,
   input  logic             enable,
   input  logic             used,
   input  srre_pkg::rec_type upstream,
   output srre_pkg::rec_type slot
);
   import srre_pkg::*;

   logic                open_ff, open_in;
   logic [PosWidth-1:0] start_ff, start_in;
   rec_type             slot_ff, slot_in;

   logic                emit_close;
   logic                emit_last;
   logic [PosWidth-1:0] close_stop;

   // A run closes at the previous position, never ending before its start.
   always_comb begin
      close_stop = (ctl.pos == '0) ? '0 : ctl.pos - 1'b1;
      if (close_stop < start_ff) begin
         close_stop = start_ff;
      end
   end

   assign emit_close = enable && !used && open_ff;
   assign emit_last  = enable && used && ctl.last;

   // Run state and pending range update.
   always_comb begin
      open_in  = open_ff;
      start_in = start_ff;
      slot_in  = slot_ff;
      if (ctl.load) begin
         slot_in.valid = emit_close || emit_last;
         slot_in.id    = IdWidth'(CELL_ID);
         if (emit_close) begin
            slot_in.start = start_ff;
            slot_in.stop  = close_stop;
         end else begin
            slot_in.start = open_ff ? start_ff : ctl.pos;
            slot_in.stop  = ctl.pos;
         end
         if (enable && used && !open_ff) begin
            open_in  = 1'b1;
            start_in = ctl.pos;
         end
         if (emit_close) begin
            open_in = 1'b0;
         end
         if (ctl.last) begin
            open_in = 1'b0;
         end
      end else if (ctl.shift) begin
         // Pending ranges move one cell toward the output per cycle while shift is set.
         slot_in = upstream;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff       <= 1'b0;
         slot_ff.valid <= 1'b0;
      end else begin
         open_ff       <= open_in;
         slot_ff.valid <= slot_in.valid;
      end
      start_ff      <= start_in;
      slot_ff.id    <= slot_in.id;
      slot_ff.start <= slot_in.start;
      slot_ff.stop  <= slot_in.stop;
   end

   assign slot = slot_ff;

endmodule

>>> src/submesh_run_range_extractor.sv
`timescale 1ns / 1ps

// Sub-mesh run range extractor. Instances arrive in sorted draw order, one per
// transfer on the req_ channel, each with a mask of the sub-meshes it uses; the
// block reports every contiguous run of a sub-mesh as an inclusive position
// range on the rsp_ channel, in ascending sub-mesh order, with last_of_run set
// on the final range caused by an instance. A row of MAX_SUBMESHES cells holds
// the open runs; every cell updates in the cycle the instance is taken and
// parks its finished range, and the row then shifts toward the output one cell
// per cycle while the result side is not stalling. An instance that ends no run
// does not hold off the next one; otherwise the next instance waits until every
// parked range has left the row. Register 0 at byte address 0 holds
// num_submeshes (reset 64, clamped to MAX_SUBMESHES); write it only while idle.
// A final instance closes all runs and resets the position.
module submesh_run_range_extractor #(
   parameter int MAX_SUBMESHES = srre_pkg::DefaultMaxSubmeshes,
   parameter int MAX_ITEMS     = srre_pkg::DefaultMaxItems
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [srre_pkg::MaskWidth-1:0]      req_submesh_mask,
   input  logic                                req_last_item,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [srre_pkg::IdWidth-1:0]        rsp_submesh_id,
   output logic [srre_pkg::PosWidth-1:0]       rsp_range_start,
   output logic [srre_pkg::PosWidth-1:0]       rsp_range_end,
   output logic                                rsp_last_of_run,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [srre_pkg::CsrAddrWidth-1:0]   paddr,
   input  logic [srre_pkg::CsrDataWidth-1:0]   pwdata,
   output logic [srre_pkg::CsrDataWidth-1:0]   prdata,
   output logic                                pready
);
   import srre_pkg::*;

   localparam logic [CountWidth-1:0] MaxCount = CountWidth'(MAX_SUBMESHES);
   localparam logic [PosWidth-1:0]   PosMax   = PosWidth'(MAX_ITEMS - 1);

   logic [CountWidth-1:0] num_ff, num_in;
   logic [PosWidth-1:0]   pos_ff, pos_in;
   logic [CountWidth-1:0] num_eff;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [IdWidth-1:0]      rsp_id_ff;
   logic [PosWidth-1:0]     rsp_start_ff, rsp_stop_ff;
   logic                    rsp_last_ff;

   ctl_type                 ctl;
   rec_type                 slots [MAX_SUBMESHES];
   logic [MAX_SUBMESHES-1:0] pend;
   logic                    busy;
   logic                    accept;
   logic                    out_free;
   logic                    head_out;

   // Configuration register.
   always_comb begin
      num_in = num_ff;
      if (psel && penable && pwrite && paddr[2] == RegNumSubmeshes[2]) begin
         num_in = pwdata[CountWidth-1:0];
      end
   end

   assign pready = 1'b1;
   assign prdata = (paddr[2] == RegNumSubmeshes[2]) ?
                   {{(CsrDataWidth-CountWidth){1'b0}}, num_ff} : '0;

   assign num_eff = (num_ff > MaxCount) ? MaxCount : num_ff;

   // Handshake and chain control.
   assign busy      = (pend != '0);
   assign req_ready = !busy;
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign head_out  = slots[0].valid && out_free;

   always_comb begin
      ctl.load  = accept;
      ctl.last  = req_last_item;
      ctl.shift = busy && (!slots[0].valid || out_free);
      ctl.pos   = pos_ff;
   end

   // Position counter saturates and restarts after the final instance.
   always_comb begin
      pos_in = pos_ff;
      if (accept) begin
         if (req_last_item) begin
            pos_in = '0;
         end else if (pos_ff < PosMax) begin
            pos_in = pos_ff + 1'b1;
         end
      end
   end

   // Row of run cells, chained toward cell zero.
   for (genvar i = 0; i < MAX_SUBMESHES; i++) begin : g_cell
      logic    cell_en;
      rec_type up;

      assign cell_en = (CountWidth'(i) < num_eff);
      assign pend[i] = slots[i].valid;

      if (i == MAX_SUBMESHES - 1) begin : g_top
         assign up = '0;
      end else begin : g_mid
         assign up = slots[i+1];
      end

      srre_cell #(
         .CELL_ID (i)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl),
         .enable   (cell_en),
         .used     (req_submesh_mask[i]),
         .upstream (up),
         .slot     (slots[i])
      );
   end

   // Output register: the head range is the final one when no other waits.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (head_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_ff       <= NumSubmeshesReset;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         num_ff       <= num_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (head_out) begin
         rsp_id_ff    <= slots[0].id;
         rsp_start_ff <= slots[0].start;
         rsp_stop_ff  <= slots[0].stop;
         rsp_last_ff  <= ((pend >> 1) == '0);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_submesh_id  = rsp_id_ff;
   assign rsp_range_start = rsp_start_ff;
   assign rsp_range_end   = rsp_stop_ff;
   assign rsp_last_of_run = rsp_last_ff;

endmodule
